FILE: hdl/sms_pkg.sv
// Shared types and constants for the sorted matrix staircase search block.
// Holds the command word, the result word, the operation codes and the register indexes.
// No dependencies.
package sms_pkg;

  // Field widths of the command and result words and of the configuration port
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // Reset value of both area-size registers
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  // Command word
  typedef struct packed {
    op_e                      operation;
    logic [IDX_W-1:0]         entry_row;
    logic [IDX_W-1:0]         entry_col;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_row;
    logic [IDX_W-1:0] found_col;
  } res_t;

endpackage

FILE: hdl/sorted_matrix_staircase_search.sv
// Top level of the sorted matrix staircase search block.
// Depends on sms_pkg and sms_mem.
//
// Usage:
//   Command channel: a word on cmd_i is taken at a rising edge where start is high and
//   busy is low. A write word stores entry_value at (entry_row, entry_col) in that same
//   edge and gives no result; a write outside the matrix is dropped. A search word walks
//   the area in use from its top-right corner, down when the entry is below the key and
//   left when it is above, until a match or until it leaves the area.
//   Result channel: res_valid_o is high for exactly one cycle with res_o; the receiver
//   cannot stall it. found_row/found_col are zero when nothing matched.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at the clock edge
//   (0 = rows_in_use, 1 = cols_in_use); sizes above the matrix clamp to its size.
// Search walk:
//   A write does not raise busy. A search reads k entries (1 <= k <= rows + cols - 1),
//   holds busy while it walks and raises res_valid_o as busy falls, so the next word can
//   go in once busy is low. The walk is bound by the store's single read port: one entry
//   read per cycle. An empty area answers in the cycle after the take.
// Reset:
//   rst_ni clears the controller and sets both sizes to 16; matrix contents are not
//   cleared and must be written before they are searched.
module sorted_matrix_staircase_search #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  sms_pkg::cmd_t                     cmd_i,
  output logic                              res_valid_o,
  output sms_pkg::res_t                     res_o,
  input  logic                              cfg_we_i,
  input  logic [sms_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sms_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import sms_pkg::*;

  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned CMP_W  = 10;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e                   state_q;
  logic [CFG_W-1:0]         rows_cfg_q, cols_cfg_q;
  logic [CFG_W-1:0]         row_q, row_d;
  logic [CFG_W-1:0]         colp_q, colp_d;   // column index plus one
  logic signed [DATA_W-1:0] key_q;
  logic                     res_valid_q;
  res_t                     res_q;

  logic [CFG_W-1:0]         rows_lim, cols_lim;
  logic                     take;
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic                     wr_in_range;
  logic signed [DATA_W-1:0] entry;
  logic                     ent_lt, ent_gt;
  logic [CFG_W-1:0]         rd_row, rd_colp;

  // Area in use, clamped to the matrix size
  assign rows_lim = (CMP_W'(rows_cfg_q) > CMP_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_cfg_q;
  assign cols_lim = (CMP_W'(cols_cfg_q) > CMP_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_cfg_q;

  assign busy = (state_q != ST_IDLE);
  assign take = start && !busy;

  // Store write path
  assign wr_in_range = (CMP_W'(cmd_i.entry_row) < CMP_W'(MAX_ROWS)) &&
                       (CMP_W'(cmd_i.entry_col) < CMP_W'(MAX_COLS));
  assign mem_we = take && (cmd_i.operation == OP_WRITE) && wr_in_range;
  assign waddr  = {ROW_W'(cmd_i.entry_row), COL_W'(cmd_i.entry_col)};

  // Compare the entry read last cycle with the key
  assign ent_lt = (entry < key_q);
  assign ent_gt = (key_q < entry);

  // Next walk position and read request
  always_comb begin
    row_d   = row_q;
    colp_d  = colp_q;
    mem_re  = 1'b0;
    rd_row  = row_q;
    rd_colp = colp_q;
    unique case (state_q)
      ST_IDLE: begin
        row_d  = '0;
        colp_d = cols_lim;
        rd_row  = '0;
        rd_colp = cols_lim;
        mem_re = take && (cmd_i.operation == OP_SEARCH) &&
                 (rows_lim != '0) && (cols_lim != '0);
      end
      ST_WALK: begin
        if (ent_lt) begin
          row_d  = row_q + 1'b1;
          rd_row = row_d;
          mem_re = (row_d < rows_lim);
        end else if (ent_gt) begin
          colp_d  = colp_q - 1'b1;
          rd_colp = colp_d;
          mem_re  = (colp_d != '0);
        end
      end
      default: ;
    endcase
  end

  assign raddr = {ROW_W'(rd_row), COL_W'(rd_colp - 1'b1)};

  sms_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.entry_value),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (entry)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= CFG_RESET;
      cols_cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_IN_USE: rows_cfg_q <= cfg_wdata_i;
        CFG_COLS_IN_USE: cols_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Walk controller and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (take && (cmd_i.operation == OP_SEARCH)) begin
            if (mem_re) begin
              state_q <= ST_WALK;
            end else begin
              // empty area: nothing to read
              res_valid_q <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (!mem_re) begin
            state_q     <= ST_IDLE;
            res_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Walk position, key and result payload
  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    colp_q <= colp_d;
    if (take) begin
      key_q <= cmd_i.search_key;
    end
    if (state_q == ST_IDLE) begin
      res_q <= '0;
    end else if (!ent_lt && !ent_gt) begin
      res_q.found     <= 1'b1;
      res_q.found_row <= IDX_W'(row_q);
      res_q.found_col <= IDX_W'(colp_q - 1'b1);
    end else begin
      res_q <= '0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: hdl/sms_mem.sv
// Matrix entry store: one write port, one read port with registered read data.
// Depends on sms_pkg for the entry width.
module sms_mem #(
  parameter int unsigned ADDR_W = 8
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [ADDR_W-1:0]                 waddr_i,
  input  logic signed [sms_pkg::DATA_W-1:0] wdata_i,
  input  logic                              re_i,
  input  logic [ADDR_W-1:0]                 raddr_i,
  output logic signed [sms_pkg::DATA_W-1:0] rdata_o
);
  import sms_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
